FILE: src/olvr_pkg.sv
// ----------------------------------------------------------------------------
// olvr_pkg
// shared constants and types for the ordered list with value removal
// ----------------------------------------------------------------------------
package olvr_pkg;

  localparam int CAPACITY      = 16;
  localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W       = $clog2(CAPACITY + 1);
  localparam int VALUE_W       = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_APPEND      = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_TAIL = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_HEAD = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_VAL  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

FILE: src/olvr_store.sv
// ----------------------------------------------------------------------------
// olvr_store
// entry storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module olvr_store (
  input  logic                         clk,
  input  olvr_pkg::mem_wr_t            wr,
  input  olvr_pkg::mem_rd_t            rd,
  output logic [olvr_pkg::VALUE_W-1:0] rd_data
);
  import olvr_pkg::*;

  logic [VALUE_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

FILE: src/ordered_list_with_value_removal.sv
// ----------------------------------------------------------------------------
// ordered_list_with_value_removal
// append, remove tail, remove head and remove first match on an ordered list
// append and remove tail: from idle to done, which registers the result
// remove head and remove first match: scan, then done; one store read and
//   one write-back per cycle while the list is walked and the gap is closed
// one item at a time; the next item is taken once the result is registered
// reset: synchronous, empties the list; entry storage is not cleared
// ----------------------------------------------------------------------------
module ordered_list_with_value_removal (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [olvr_pkg::OP_W-1:0]           operation,
  input  logic signed [olvr_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [olvr_pkg::STATUS_W-1:0]       status,
  output logic [olvr_pkg::ENTRY_COUNT_W-1:0]  entry_count
);
  import olvr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  scan_cnt;
  logic [ADDR_W-1:0]   d_idx;
  logic                rd_pend;
  logic                found;
  logic [OP_W-1:0]     op;
  logic [VALUE_W-1:0]  key;
  logic [STATUS_W-1:0] res_status;

  mem_wr_t            wr;
  mem_rd_t            rd;
  logic [VALUE_W-1:0] rd_data;

  logic accept;
  logic hit;
  logic last;

  olvr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign hit  = (op == OP_REMOVE_HEAD) ? (d_idx == '0) : (rd_data == key);
  assign last = (d_idx == ADDR_W'(count - 1'b1));

  // reads run two places ahead of the write-back, so no entry overlaps
  always_comb begin
    rd.en   = (state == S_SCAN) && (scan_cnt < count);
    rd.addr = scan_cnt[ADDR_W-1:0];
    wr.en   = 1'b0;
    wr.addr = d_idx - 1'b1;
    wr.data = rd_data;
    if (accept && operation == OP_APPEND && count < COUNT_W'(CAPACITY)) begin
      wr.en   = 1'b1;
      wr.addr = count[ADDR_W-1:0];
      wr.data = value;
    end else if (state == S_SCAN && rd_pend && found) begin
      wr.en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= operation;
            key      <= value;
            scan_cnt <= '0;
            rd_pend  <= 1'b0;
            found    <= 1'b0;
            state    <= S_DONE;
            case (operation)
              OP_APPEND: begin
                if (count < COUNT_W'(CAPACITY)) begin
                  count      <= count + 1'b1;
                  res_status <= ST_OK;
                end else begin
                  res_status <= ST_FULL;
                end
              end
              OP_REMOVE_TAIL: begin
                if (count != '0) begin
                  count      <= count - 1'b1;
                  res_status <= ST_OK;
                end else begin
                  res_status <= ST_EMPTY;
                end
              end
              default: begin
                if (count != '0) begin
                  state <= S_SCAN;
                end else begin
                  res_status <= ST_EMPTY;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_pend <= rd.en;
          d_idx   <= scan_cnt[ADDR_W-1:0];
          if (rd.en) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (rd_pend) begin
            if (!found && hit) begin
              found <= 1'b1;
            end
            if (last) begin
              rd_pend <= 1'b0;
              state   <= S_DONE;
              if (found || hit) begin
                count      <= count - 1'b1;
                res_status <= ST_OK;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            entry_count <= ENTRY_COUNT_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_shift_after_hit: assert property (@(posedge clk) disable iff (rst)
    (wr.en && state == S_SCAN) |-> found)
    else $error("gap closed before a match");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result shown outside done state");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd.en |-> (state == S_SCAN && scan_cnt < count))
    else $error("read past the list tail");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> !$past(accept))
    else $error("item taken during a scan");

endmodule
